// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the remap table RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== hw/rtl/rwrt_pkg.sv =====
// Package for the refcounted remap window table: types, codes and sizes.
// No dependencies; imported by the scan unit, the top level and the testbench.
package rwrt_pkg;

	localparam int RWRT_ENTRIES   = 64;
	localparam int RWRT_PAGE_LOG2 = 12;
	localparam int FRAME_SHIFT    = 12;
	localparam int FRAME_W        = 20;
	localparam int REFS_W         = 12;
	localparam int ADDR_W         = 32;

	localparam logic [REFS_W-1:0] REF_MAX = '1;

	// Request op codes
	localparam logic [1:0] OP_MAP    = 2'd0;
	localparam logic [1:0] OP_UNMAP  = 2'd1;
	localparam logic [1:0] OP_LOCATE = 2'd2;

	// Response status codes
	localparam logic [3:0] STS_HIT        = 4'd0;
	localparam logic [3:0] STS_NEW        = 4'd1;
	localparam logic [3:0] STS_FULL       = 4'd2;
	localparam logic [3:0] STS_GRANT_FAIL = 4'd3;
	localparam logic [3:0] STS_NOT_MAPPED = 4'd4;
	localparam logic [3:0] STS_RELEASED   = 4'd5;
	localparam logic [3:0] STS_FREED      = 4'd6;
	localparam logic [3:0] STS_LOCATED    = 4'd7;
	localparam logic [3:0] STS_SATURATED  = 4'd8;

	typedef struct packed {
		logic [1:0]        op;
		logic [ADDR_W-1:0] phys_addr;
		logic [4:0]        size_log2;
		logic              backing_ok;
	} req_t;

	typedef struct packed {
		logic [3:0]        status;
		logic [5:0]        window_index;
		logic [ADDR_W-1:0] mapped_addr;
		logic [REFS_W-1:0] ref_count;
	} rsp_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [REFS_W-1:0]  refs;
	} entry_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_UPDATE
	} state_t;

	// Sequencer to scan unit
	typedef struct packed {
		logic clear;
		logic check;
	} scan_ctl_t;

	// Scan unit to sequencer
	typedef struct packed {
		logic hit;
		logic free;
	} scan_flags_t;

endpackage

// ===== hw/rtl/rwrt_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// Depends on nothing; used for the remap entry store.
module rwrt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/rwrt_scan.sv =====
// Scan unit: compares one table entry per cycle, while ctl.check is high, against the request frame
// and keeps the lowest matching used entry and the lowest free entry. Uses rwrt_pkg.
module rwrt_scan
	import rwrt_pkg::*;
#(
	parameter int ENTRIES = RWRT_ENTRIES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  scan_ctl_t                  ctl,
	input  logic [$clog2(ENTRIES)-1:0] idx,
	input  entry_t                     entry,
	input  logic [FRAME_W-1:0]         key,
	output scan_flags_t                flags,
	output logic [$clog2(ENTRIES)-1:0] hit_idx,
	output logic [REFS_W-1:0]          hit_refs,
	output logic [$clog2(ENTRIES)-1:0] free_idx
);

	localparam int IDX_W = $clog2(ENTRIES);

	logic             hit_q;
	logic             free_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [REFS_W-1:0] hit_refs_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             used;
	logic             match;

	// Compare the current entry
	assign used  = (entry.refs != '0);
	assign match = used && (entry.frame == key);

	// Track first hit and first free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (ctl.check) begin
			if (!hit_q && match) begin
				hit_q <= 1'b1;
			end
			if (!free_q && !used) begin
				free_q <= 1'b1;
			end
		end
	end

	// Capture index and count of the first hit and free slot
	always_ff @(posedge clk) begin
		if (ctl.check && !ctl.clear) begin
			if (!hit_q && match) begin
				hit_idx_q  <= idx;
				hit_refs_q <= entry.refs;
			end
			if (!free_q && !used) begin
				free_idx_q <= idx;
			end
		end
	end

	assign flags.hit  = hit_q;
	assign flags.free = free_q;
	assign hit_idx    = hit_idx_q;
	assign hit_refs   = hit_refs_q;
	assign free_idx   = free_idx_q;

endmodule

// ===== hw/rtl/refcounted_window_remap_table_core.sv =====
// Top level of the refcounted remap window table: sequencer, entry RAM,
// scan unit and response register. Uses rwrt_pkg, rwrt_ram, rwrt_scan.
//
//   channel  | signals                      | carries
//   ---------+------------------------------+--------------------------------
//   req      | req_valid, req_ready, req    | op, phys_addr, size_log2, grant
//   rsp      | rsp_valid, rsp_ready, rsp    | status, index, address, count
//   cfg      | cfg_valid, cfg_ready, window_base | window base register
//
// After reset the entry RAM is cleared, one entry per cycle, with req_ready
// low; cfg writes are taken at any time.
// After a request is taken req_ready stays low while S_SCAN reads every entry through
// the single RAM read port and compares the last one and S_UPDATE writes the table; it
// rises again in S_IDLE, so a new request is taken only after the previous update.
// The response sits in an output register; a stalled rsp holds the next
// request in its update cycle until the register frees.
`include "assert_macros.svh"
module refcounted_window_remap_table_core
	import rwrt_pkg::*;
#(
	parameter int ENTRIES   = RWRT_ENTRIES,
	parameter int PAGE_LOG2 = RWRT_PAGE_LOG2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [ADDR_W-1:0] window_base
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [FRAME_W-1:0] FRAME_LO_MASK =
		FRAME_W'((1 << (PAGE_LOG2 - FRAME_SHIFT)) - 1);
	localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'((64'd1 << PAGE_LOG2) - 1);

	state_t            state_q;
	state_t            state_d;
	logic [ADDR_W-1:0] window_base_q;
	req_t              req_q;
	logic [IDX_W-1:0]  clr_idx_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic              rd_done_q;
	logic              chk_vld_s1;
	logic              chk_last_s1;
	logic [IDX_W-1:0]  chk_idx_s1;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              accept;
	logic              rd_issue;
	logic              upd_fire;
	logic              clr_we;
	logic              clr_last;
	logic [FRAME_W-1:0] key;

	scan_ctl_t         scan_ctl;
	scan_flags_t       scan_flags;
	logic [IDX_W-1:0]  hit_idx;
	logic [REFS_W-1:0] hit_refs;
	logic [IDX_W-1:0]  free_idx;

	entry_t            rd_entry;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	entry_t            ram_wdata;

	logic              upd_we;
	logic [IDX_W-1:0]  upd_idx;
	entry_t            upd_entry;
	logic [3:0]        upd_sts;
	logic              upd_has_entry;
	logic [REFS_W-1:0] upd_refs;
	logic [REFS_W-1:0] dec_refs;
	logic [ADDR_W-1:0] upd_addr;
	rsp_t              rsp_d;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_base_q <= '0;
		end else if (cfg_valid) begin
			window_base_q <= window_base;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (chk_last_s1) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		req_ready = 1'b0;
		clr_we    = 1'b0;
		rd_issue  = 1'b0;
		upd_fire  = 1'b0;
		unique case (state_q)
			S_CLEAR:  clr_we = 1'b1;
			S_IDLE:   req_ready = 1'b1;
			S_SCAN:   rd_issue = !rd_done_q;
			S_UPDATE: upd_fire = !rsp_valid_q || rsp_ready;
			default:  clr_we = 1'b0;
		endcase
	end

	assign accept   = req_valid && req_ready;
	assign clr_last = (clr_idx_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Clear pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (clr_we && !clr_last) begin
			clr_idx_q <= clr_idx_q + IDX_W'(1);
		end
	end

	// Hold the request
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	assign key = req_q.phys_addr[ADDR_W-1:FRAME_SHIFT] & ~FRAME_LO_MASK;

	// Advance the scan read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_done_q <= 1'b0;
		end else if (accept) begin
			rd_idx_q  <= '0;
			rd_done_q <= 1'b0;
		end else if (rd_issue) begin
			if (rd_idx_q == LAST_IDX) begin
				rd_done_q <= 1'b1;
			end else begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
		end
	end

	// Track read data arriving from the RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_vld_s1  <= 1'b0;
			chk_last_s1 <= 1'b0;
		end else begin
			chk_vld_s1  <= rd_issue;
			chk_last_s1 <= rd_issue && (rd_idx_q == LAST_IDX);
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_idx_q;
	end

	// Entry store
	assign ram_we    = clr_we || (upd_fire && upd_we);
	assign ram_waddr = clr_we ? clr_idx_q : upd_idx;
	assign ram_wdata = clr_we ? entry_t'('0) : upd_entry;

	rwrt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_idx_q),
		.rdata (rd_entry)
	);

	// Compare unit
	assign scan_ctl.clear = accept;
	assign scan_ctl.check = chk_vld_s1;

	rwrt_scan #(
		.ENTRIES (ENTRIES)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.idx      (chk_idx_s1),
		.entry    (rd_entry),
		.key      (key),
		.flags    (scan_flags),
		.hit_idx  (hit_idx),
		.hit_refs (hit_refs),
		.free_idx (free_idx)
	);

	// Decide the table update and the response
	assign dec_refs = hit_refs - REFS_W'(1);

	always_comb begin
		upd_we        = 1'b0;
		upd_idx       = hit_idx;
		upd_entry     = '{frame: key, refs: hit_refs};
		upd_sts       = STS_NOT_MAPPED;
		upd_has_entry = 1'b0;
		upd_refs      = '0;
		unique case (req_q.op)
			OP_MAP: begin
				priority if (scan_flags.hit) begin
					upd_has_entry = 1'b1;
					if (hit_refs == REF_MAX) begin
						upd_sts  = STS_SATURATED;
						upd_refs = REF_MAX;
					end else begin
						upd_sts        = STS_HIT;
						upd_we         = 1'b1;
						upd_refs       = hit_refs + REFS_W'(1);
						upd_entry.refs = upd_refs;
					end
				end else if (!scan_flags.free) begin
					upd_sts = STS_FULL;
				end else if (!req_q.backing_ok) begin
					upd_sts = STS_GRANT_FAIL;
				end else begin
					upd_sts       = STS_NEW;
					upd_has_entry = 1'b1;
					upd_we        = 1'b1;
					upd_idx       = free_idx;
					upd_refs      = REFS_W'(1);
					upd_entry     = '{frame: key, refs: REFS_W'(1)};
				end
			end
			OP_UNMAP: begin
				if (scan_flags.hit) begin
					upd_has_entry = 1'b1;
					upd_we        = 1'b1;
					upd_refs      = dec_refs;
					if (dec_refs == '0) begin
						upd_sts   = STS_FREED;
						upd_entry = '0;
					end else begin
						upd_sts        = STS_RELEASED;
						upd_entry.refs = dec_refs;
					end
				end
			end
			default: begin
				// Locate and the spare code only locate the entry
				if (scan_flags.hit) begin
					upd_has_entry = 1'b1;
					upd_sts       = STS_LOCATED;
					upd_refs      = hit_refs;
				end
			end
		endcase
	end

	// Window address: base plus entry page plus page offset
	assign upd_addr = window_base_q
		+ ((ADDR_W'(upd_idx) << PAGE_LOG2) | (req_q.phys_addr & PAGE_MASK));

	always_comb begin
		rsp_d.status       = upd_sts;
		rsp_d.window_index = upd_has_entry ? 6'(upd_idx) : '0;
		rsp_d.mapped_addr  = upd_has_entry ? upd_addr : '0;
		rsp_d.ref_count    = upd_refs;
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (upd_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	`ASSERT_AT(a_last_in_scan, clk, arst_n, chk_last_s1 |-> state_q == S_SCAN, "scan end outside scan")
	`ASSERT_AT(a_hit_used, clk, arst_n, (state_q == S_UPDATE && scan_flags.hit) |-> hit_refs != '0, "hit on free entry")
	`ASSERT_AT(a_fire_loads_rsp, clk, arst_n, upd_fire |=> rsp_valid_q, "update did not load response")
	`ASSERT_AT(a_live_count, clk, arst_n, (rsp_valid_q && (rsp_q.status == STS_HIT || rsp_q.status == STS_NEW || rsp_q.status == STS_RELEASED)) |-> rsp_q.ref_count != '0, "live entry with zero count")
	`ASSERT_AT(a_none_zero, clk, arst_n, (rsp_valid_q && (rsp_q.status == STS_FULL || rsp_q.status == STS_GRANT_FAIL || rsp_q.status == STS_NOT_MAPPED)) |-> (rsp_q.window_index == '0 && rsp_q.mapped_addr == '0), "no-entry response carries an index")

endmodule

// ===== tb/sv/refcounted_window_remap_table_core_test.sv =====
// Self-checking testbench for refcounted_window_remap_table_core: directed and random
// map, unmap and locate requests checked against a behavioral model of the window table.
// Depends on rwrt_pkg and the RTL of the block only.
module refcounted_window_remap_table_core_test;
	import rwrt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CLK_PERIOD  = 8;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int          POOL_SIZE   = 96;
	localparam logic [1:0]  OP_SPARE    = 2'd3;   // unused code, acts as locate
	localparam logic [ADDR_W-1:0] PAGE_MASK = (32'd1 << RWRT_PAGE_LOG2) - 1;

	typedef enum logic [1:0] {
		JOB_REQ,
		JOB_PHASE,
		JOB_DRAIN
	} job_t;

	typedef struct {
		job_t              job;
		req_t              req;
		logic [ADDR_W-1:0] base;
		int unsigned       send_idle;
		int unsigned       rsp_stall;
	} plan_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	req_t              req = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	rsp_t              rsp;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [ADDR_W-1:0] window_base = '0;

	// Model of the table and its base register
	logic [FRAME_W-1:0] win_frame [RWRT_ENTRIES] = '{default: '0};
	logic [REFS_W-1:0]  win_refs  [RWRT_ENTRIES] = '{default: '0};
	logic [ADDR_W-1:0]  table_base = '0;

	plan_t              req_plan_q [$];
	rsp_t               expected_rsp_q [$];
	logic [FRAME_W-1:0] frame_pool [POOL_SIZE];

	int unsigned req_sent = 0, req_acc_cnt = 0;
	int unsigned cfg_sent = 0, cfg_acc_cnt = 0;
	int unsigned send_idle = 0, rsp_stall = 0;
	int unsigned cycle_cnt = 0, rsp_seq = 0, err_cnt = 0;

	refcounted_window_remap_table_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.window_base (window_base)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [ADDR_W-1:0] window_of(input int idx, input logic [ADDR_W-1:0] addr);
		return table_base + (ADDR_W'(idx) << RWRT_PAGE_LOG2) + (addr & PAGE_MASK);
	endfunction

	// Apply one request to the table model and return its response
	function automatic rsp_t remap_lookup(input req_t r);
		logic [FRAME_W-1:0] frame;
		int                 hit, slot;
		rsp_t               res;
		frame = FRAME_W'((r.phys_addr & ~PAGE_MASK) >> FRAME_SHIFT);
		res   = '0;
		hit   = -1;
		slot  = -1;
		for (int i = 0; i < RWRT_ENTRIES; i++) begin
			if (hit < 0 && win_refs[i] != '0 && win_frame[i] == frame)
				hit = i;
			if (slot < 0 && win_refs[i] == '0)
				slot = i;
		end
		if (r.op == OP_MAP) begin
			if (hit >= 0) begin
				res.window_index = 6'(hit);
				res.mapped_addr  = window_of(hit, r.phys_addr);
				if (win_refs[hit] == REF_MAX) begin
					res.status    = STS_SATURATED;
					res.ref_count = REF_MAX;
				end else begin
					win_refs[hit] = win_refs[hit] + 1'b1;
					res.status    = STS_HIT;
					res.ref_count = win_refs[hit];
				end
			end else if (slot < 0) begin
				res.status = STS_FULL;
			end else if (!r.backing_ok) begin
				res.status = STS_GRANT_FAIL;
			end else begin
				win_frame[slot]  = frame;
				win_refs[slot]   = REFS_W'(1);
				res.status       = STS_NEW;
				res.window_index = 6'(slot);
				res.mapped_addr  = window_of(slot, r.phys_addr);
				res.ref_count    = REFS_W'(1);
			end
		end else if (hit < 0) begin
			res.status = STS_NOT_MAPPED;
		end else begin
			res.window_index = 6'(hit);
			res.mapped_addr  = window_of(hit, r.phys_addr);
			if (r.op != OP_UNMAP) begin
				res.status    = STS_LOCATED;
				res.ref_count = win_refs[hit];
			end else begin
				win_refs[hit] = win_refs[hit] - 1'b1;
				res.ref_count = win_refs[hit];
				if (win_refs[hit] == '0) begin
					win_frame[hit] = '0;
					res.status     = STS_FREED;
				end else begin
					res.status = STS_RELEASED;
				end
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t: response %0d: %s", $time, rsp_seq, what);
		err_cnt++;
	endtask

	task automatic check_field(input string name, input logic [ADDR_W-1:0] got,
			input logic [ADDR_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
	endtask

	function automatic req_t mk_req(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
			input logic [4:0] size_log2, input logic ok);
		req_t r;
		r.op         = op;
		r.phys_addr  = addr;
		r.size_log2  = size_log2;
		r.backing_ok = ok;
		return r;
	endfunction

	task automatic plan_req(input req_t r);
		plan_t p;
		p     = '{job: JOB_REQ, req: r, base: '0, send_idle: 0, rsp_stall: 0};
		req_plan_q.push_back(p);
	endtask

	task automatic plan_phase(input logic [ADDR_W-1:0] base, input int unsigned idle,
			input int unsigned stall);
		plan_t p;
		p     = '{job: JOB_PHASE, req: '0, base: base, send_idle: idle, rsp_stall: stall};
		req_plan_q.push_back(p);
	endtask

	task automatic plan_drain();
		plan_t p;
		p     = '{job: JOB_DRAIN, req: '0, base: '0, send_idle: 0, rsp_stall: 0};
		req_plan_q.push_back(p);
	endtask

	// Mostly requests on a small frame pool so that entries get reused; noise is fully random
	task automatic plan_random(input int unsigned n, input int unsigned pool_n,
			input int unsigned w_map, input int unsigned w_unmap, input int unsigned noise);
		req_t        r;
		int unsigned roll;
		for (int unsigned k = 0; k < n; k++) begin
			r.size_log2  = 5'($urandom_range(31));
			r.backing_ok = ($urandom_range(99) < 85);
			if ($urandom_range(99) < noise) begin
				r.op        = 2'($urandom_range(3));
				r.phys_addr = $urandom();
			end else begin
				roll = $urandom_range(99);
				if (roll < w_map)
					r.op = OP_MAP;
				else if (roll < w_map + w_unmap)
					r.op = OP_UNMAP;
				else if (roll % 4 == 0)
					r.op = OP_SPARE;
				else
					r.op = OP_LOCATE;
				r.phys_addr = {frame_pool[$urandom_range(pool_n - 1)],
					RWRT_PAGE_LOG2'($urandom_range(4095))};
			end
			plan_req(r);
			if ($urandom_range(99) < 2)
				plan_drain();
		end
	endtask

	// Driver: feed requests, config writes and response backpressure at the falling edge
	always @(negedge clk) begin
		logic              nv, ncv;
		req_t              nreq;
		logic [ADDR_W-1:0] nbase;
		plan_t             nxt;
		nv    = req_valid;
		ncv   = cfg_valid;
		nreq  = req;
		nbase = window_base;
		if (arst_n) begin
			// drop valid once the request or write has been taken
			if (req_valid && req_acc_cnt == req_sent)
				nv = 1'b0;
			if (cfg_valid && cfg_acc_cnt == cfg_sent)
				ncv = 1'b0;
			if (!nv && !ncv && req_plan_q.size() != 0) begin
				nxt = req_plan_q[0];
				unique case (nxt.job)
					JOB_REQ: begin
						if ($urandom_range(99) >= send_idle) begin
							nv   = 1'b1;
							nreq = nxt.req;
							req_sent++;
							void'(req_plan_q.pop_front());
						end
					end
					JOB_PHASE: begin
						if (expected_rsp_q.size() == 0) begin
							ncv       = 1'b1;
							nbase     = nxt.base;
							send_idle = nxt.send_idle;
							rsp_stall = nxt.rsp_stall;
							cfg_sent++;
							void'(req_plan_q.pop_front());
						end
					end
					default: begin
						if (expected_rsp_q.size() == 0)
							void'(req_plan_q.pop_front());
					end
				endcase
			end
			rsp_ready <= ($urandom_range(99) >= rsp_stall);
		end
		req_valid   <= nv;
		req         <= nreq;
		cfg_valid   <= ncv;
		window_base <= nbase;
	end

	// Monitor: check responses, predict accepted requests, track base writes
	always @(posedge clk) begin
		rsp_t want;
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp_q.size() == 0) begin
					report_mismatch("response with no request outstanding");
				end else begin
					want = expected_rsp_q.pop_front();
					check_field("status", ADDR_W'(rsp.status), ADDR_W'(want.status));
					check_field("window_index", ADDR_W'(rsp.window_index),
						ADDR_W'(want.window_index));
					check_field("mapped_addr", rsp.mapped_addr, want.mapped_addr);
					check_field("ref_count", ADDR_W'(rsp.ref_count), ADDR_W'(want.ref_count));
				end
				rsp_seq++;
			end
			if (req_valid && req_ready) begin
				expected_rsp_q.push_back(remap_lookup(req));
				req_acc_cnt++;
			end
			if (cfg_valid && cfg_ready) begin
				table_base = window_base;
				cfg_acc_cnt++;
			end
		end
	end

	initial begin
		for (int i = 0; i < POOL_SIZE; i++)
			frame_pool[i] = FRAME_W'($urandom());

		// Directed: unknown frames, grant failure, hit, locate, release, free, wrap
		plan_phase(32'hFFFF_F000, 0, 0);
		plan_req(mk_req(OP_UNMAP,  32'h0000_0000, 5'd0,  1'b0));
		plan_req(mk_req(OP_LOCATE, 32'hFFFF_FFFF, 5'd31, 1'b1));
		plan_req(mk_req(OP_SPARE,  32'h1234_5678, 5'd5,  1'b1));
		plan_req(mk_req(OP_MAP,    32'h0000_0000, 5'd0,  1'b0));
		plan_req(mk_req(OP_MAP,    32'hFFFF_FFFF, 5'd31, 1'b1));
		plan_req(mk_req(OP_MAP,    32'hFFFF_F000, 5'd12, 1'b0));
		plan_req(mk_req(OP_LOCATE, 32'hFFFF_F800, 5'd3,  1'b0));
		plan_req(mk_req(OP_SPARE,  32'hFFFF_FABC, 5'd7,  1'b1));
		plan_req(mk_req(OP_UNMAP,  32'hFFFF_F001, 5'd16, 1'b1));
		plan_req(mk_req(OP_UNMAP,  32'hFFFF_F002, 5'd10, 1'b0));
		plan_req(mk_req(OP_UNMAP,  32'hFFFF_F003, 5'd8,  1'b1));
		plan_req(mk_req(OP_MAP,    32'h0000_0FFF, 5'd1,  1'b1));
		plan_req(mk_req(OP_MAP,    32'h0000_1000, 5'd2,  1'b1));
		plan_req(mk_req(OP_LOCATE, 32'h0000_0000, 5'd0,  1'b0));

		// Random phases: fill to full, drain, mixed traffic and noise
		plan_phase(32'h0000_0000, 0, 0);
		plan_random(250, 8, 45, 35, 0);
		plan_phase($urandom() & 32'hFFFC_0000, 67, 0);
		plan_random(350, POOL_SIZE, 75, 10, 0);
		plan_drain();
		plan_phase(32'hFFFF_FFFF, 0, 67);
		plan_random(350, POOL_SIZE, 15, 70, 0);
		plan_phase($urandom(), 18, 18);
		plan_random(400, 24, 45, 35, 10);
		plan_phase($urandom(), 18, 18);
		plan_random(300, POOL_SIZE, 50, 30, 40);
		plan_phase(32'h0000_0000, 0, 0);
		plan_random(150, 8, 40, 40, 5);

		// Hold reset, then release it away from the sampling edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for all requests to be taken and answered, then let the block settle
		do
			@(posedge clk);
		while (req_plan_q.size() != 0 || req_valid || cfg_valid || expected_rsp_q.size() != 0);
		repeat (RWRT_ENTRIES + 8) @(posedge clk);

		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rwrt_pkg.sv
hw/rtl/rwrt_ram.sv
hw/rtl/rwrt_scan.sv
hw/rtl/refcounted_window_remap_table_core.sv
tb/sv/refcounted_window_remap_table_core_test.sv
